@@ rtl/motor_encoder_tracker_core_macros.svh @@
// ----------------------------------------------------------------------------
// Motor encoder tracker assertion macros
// Shorthand for the concurrent checks used inside the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MOTOR_ENCODER_TRACKER_CORE_MACROS_SVH
`define MOTOR_ENCODER_TRACKER_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define MET_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/met_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor encoder tracker package
// Field widths, fixed constants and shared types of the tracker.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int RAW_W      = 13;
    localparam int RATE_W     = 14;
    localparam int ANGLE_W    = 20;
    localparam int TURNS_W    = 32;
    localparam int POS_W      = 45;
    localparam int BIAS_CNT_W = 8;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;

    // One full turn of the encoder, in counts.
    localparam logic signed [RATE_W:0]    TURN_SPAN   = 15'sd8192;
    // 360 degrees * 1024 / 8192 counts.
    localparam logic signed [ANGLE_W-1:0] ANGLE_SCALE = 20'sd45;

    localparam logic [BIAS_CNT_W-1:0] BIAS_SAMPLES_RST   = 8'd50;
    localparam logic [RAW_W-1:0]      WRAP_THRESHOLD_RST = 13'd7000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_SAMPLES   = 1'b0,
        REG_WRAP_THRESHOLD = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                      calibrating;
        logic signed [POS_W-1:0]   position;
        logic signed [RATE_W-1:0]  raw_rate;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [TURNS_W-1:0] turns;
    } t_track_res;

endpackage

@@ rtl/met_div.sv @@
// ----------------------------------------------------------------------------
// Moving-average divider
// Divides the signed rate sum by the ring depth, truncating toward zero,
// by a multiplication with a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module met_div #(
    parameter int  RING_DEPTH = 8,
    localparam int SUM_W      = met_pkg::RATE_W + $clog2(RING_DEPTH)
) (
    input  logic signed [SUM_W-1:0]          i_sum,
    output logic signed [met_pkg::RATE_W-1:0] o_quot
);

    localparam int MAG_W    = SUM_W - 1;
    localparam int LOG_D    = $clog2(RING_DEPTH);
    localparam int SH       = MAG_W + LOG_D;
    localparam int RECIP    = ((1 << SH) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int RECIP_W  = MAG_W + 2;
    localparam int PROD_W   = MAG_W + RECIP_W;

    logic                          neg;
    logic signed [SUM_W-1:0]       abs_sum;
    logic [MAG_W-1:0]              mag;
    logic [PROD_W-1:0]             prod;
    logic [met_pkg::RATE_W-1:0]    q_mag;

    // With m below 2^MAG_W the rounded-up reciprocal gives the exact floor.
    always_comb begin
        neg     = i_sum[SUM_W-1];
        abs_sum = neg ? -i_sum : i_sum;
        mag     = abs_sum[MAG_W-1:0];
        prod    = PROD_W'(mag) * PROD_W'(RECIP);
        q_mag   = met_pkg::RATE_W'(prod >> SH);
        o_quot  = neg ? -signed'(q_mag) : signed'(q_mag);
    end

endmodule

@@ rtl/motor_encoder_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Motor encoder tracker core
// Multi-turn position, wrap-corrected rate, moving-average rate and angle
// from bias for a 13-bit absolute rotary encoder.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Ports                       Content
//  s_axis      in         tvalid/tready/tdata[15:0]   raw_position
//  m_axis      out        tvalid/tready/tdata[127:0]  position, rates, angle,
//                         tuser[0]                    turns; calibrating flag
//  cfg         in         i_cfg_we/index/wdata        bias_samples, threshold
//
//  One item per cycle unless the output stalls; an item taken passes through the
//  input, divide and output registers. The rate limit is the loop through the
//  running sum and the turn counter, updated as each item leaves the input
//  register. Reset is synchronous and clears the valid and tracking state, the
//  rate ring included. A stalled output holds the pipeline; each stage frees as
//  its successor frees, so tready drops only when all three stages are full.
//
`include "motor_encoder_tracker_core_macros.svh"

module motor_encoder_tracker_core #(
    parameter int RING_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: raw_position[12:0], zero pad[15:13]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,
    // tdata: position[44:0], raw_rate[58:45], filtered_rate[72:59],
    //        angle[92:73], turns[124:93], zero pad[127:125]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [127:0]                    m_axis_tdata,
    // tuser: calibrating[0]
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [met_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int SUM_W = met_pkg::RATE_W + $clog2(RING_DEPTH);

    // Configuration
    logic [met_pkg::BIAS_CNT_W-1:0]        r_bias_samples;
    logic [met_pkg::RAW_W-1:0]             r_wrap_thr;

    // Input stage
    logic                                  r_a_vld;
    logic [met_pkg::RAW_W-1:0]             r_a_raw;

    // Tracking state
    logic [met_pkg::BIAS_CNT_W-1:0]        r_items_seen;
    logic [met_pkg::RAW_W-1:0]             r_prev;
    logic [met_pkg::RAW_W-1:0]             r_bias;
    logic signed [met_pkg::TURNS_W-1:0]    r_turns;
    logic signed [met_pkg::RATE_W-1:0]     r_ring [RING_DEPTH];
    logic signed [SUM_W-1:0]               r_sum;
    logic signed [met_pkg::RATE_W-1:0]     r_last_rate;
    logic signed [met_pkg::ANGLE_W-1:0]    r_last_angle;

    // Divide stage and output stage
    logic                                  r_b_vld;
    met_pkg::t_track_res                   r_b_res;
    logic signed [SUM_W-1:0]               r_b_sum;
    logic                                  r_o_vld;
    met_pkg::t_track_res                   r_o_res;
    logic signed [met_pkg::RATE_W-1:0]     r_o_filt;

    logic                                  adv_o;
    logic                                  adv_b;
    logic                                  a_go;
    logic                                  calib;
    logic signed [met_pkg::RATE_W:0]       diff;
    logic signed [met_pkg::RATE_W:0]       thr;
    logic                                  wrap_up;
    logic                                  wrap_dn;
    logic signed [met_pkg::RATE_W:0]       rate_w;
    logic signed [met_pkg::RATE_W-1:0]     rate;
    logic signed [met_pkg::TURNS_W-1:0]    n_turns;
    logic signed [SUM_W-1:0]               n_sum;
    logic signed [met_pkg::RATE_W-1:0]     bias_diff;
    logic signed [met_pkg::ANGLE_W-1:0]    n_angle;
    met_pkg::t_track_res                   n_b_res;
    logic signed [SUM_W-1:0]               n_b_sum;
    logic signed [met_pkg::RATE_W-1:0]     n_o_filt;

    // Handshake: each stage advances when the one after it is free.
    assign adv_o         = !r_o_vld || m_axis_tready;
    assign adv_b         = !r_b_vld || adv_o;
    assign a_go          = r_a_vld && adv_b;
    assign s_axis_tready = !r_a_vld || adv_b;

    always_comb begin
        calib     = r_items_seen < r_bias_samples;
        diff      = signed'({2'b00, r_a_raw}) - signed'({2'b00, r_prev});
        thr       = signed'({2'b00, r_wrap_thr});
        wrap_up   = diff < -thr;
        wrap_dn   = diff > thr;
        if (wrap_up) begin
            rate_w  = diff + met_pkg::TURN_SPAN;
            n_turns = r_turns + 32'sd1;
        end else if (wrap_dn) begin
            rate_w  = diff - met_pkg::TURN_SPAN;
            n_turns = r_turns - 32'sd1;
        end else begin
            rate_w  = diff;
            n_turns = r_turns;
        end
        rate      = rate_w[met_pkg::RATE_W-1:0];
        // The oldest sample drops out of the window as the new one enters.
        n_sum     = r_sum - SUM_W'(r_ring[RING_DEPTH-1]) + SUM_W'(rate);
        bias_diff = signed'({1'b0, r_a_raw}) - signed'({1'b0, r_bias});
        n_angle   = met_pkg::ANGLE_W'(bias_diff) * met_pkg::ANGLE_SCALE;

        n_b_res.calibrating = calib;
        if (calib) begin
            n_b_res.position = signed'({{(met_pkg::POS_W - met_pkg::RAW_W){1'b0}}, r_a_raw});
            n_b_res.raw_rate = r_last_rate;
            n_b_res.angle    = r_last_angle;
            n_b_res.turns    = r_turns;
            n_b_sum          = r_sum;
        end else begin
            n_b_res.position = signed'({n_turns, r_a_raw});
            n_b_res.raw_rate = rate;
            n_b_res.angle    = n_angle;
            n_b_res.turns    = n_turns;
            n_b_sum          = n_sum;
        end
    end

    met_div #(
        .RING_DEPTH (RING_DEPTH)
    ) u_div (
        .i_sum  (r_b_sum),
        .o_quot (n_o_filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_samples <= met_pkg::BIAS_SAMPLES_RST;
            r_wrap_thr     <= met_pkg::WRAP_THRESHOLD_RST;
            r_a_vld        <= 1'b0;
            r_b_vld        <= 1'b0;
            r_o_vld        <= 1'b0;
            r_items_seen   <= '0;
            r_prev         <= '0;
            r_bias         <= '0;
            r_turns        <= '0;
            r_sum          <= '0;
            r_last_rate    <= '0;
            r_last_angle   <= '0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (met_pkg::t_cfg_reg'(i_cfg_index))
                    met_pkg::REG_BIAS_SAMPLES: begin
                        r_bias_samples <= i_cfg_wdata[met_pkg::BIAS_CNT_W-1:0];
                    end
                    met_pkg::REG_WRAP_THRESHOLD: begin
                        r_wrap_thr <= i_cfg_wdata[met_pkg::RAW_W-1:0];
                    end
                endcase
            end

            if (s_axis_tready) begin
                r_a_vld <= s_axis_tvalid;
            end
            if (adv_b) begin
                r_b_vld <= r_a_vld;
            end
            if (adv_o) begin
                r_o_vld <= r_b_vld;
            end

            if (a_go) begin
                r_prev <= r_a_raw;
                if (calib) begin
                    r_bias       <= r_a_raw;
                    r_items_seen <= r_items_seen + 8'd1;
                end else begin
                    r_turns      <= n_turns;
                    r_sum        <= n_sum;
                    r_last_rate  <= rate;
                    r_last_angle <= n_angle;
                    r_ring[0]    <= rate;
                    for (int k = 1; k < RING_DEPTH; k++) begin
                        r_ring[k] <= r_ring[k-1];
                    end
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_a_raw <= s_axis_tdata[met_pkg::RAW_W-1:0];
        end
        if (a_go) begin
            r_b_res <= n_b_res;
            r_b_sum <= n_b_sum;
        end
        if (r_b_vld && adv_o) begin
            r_o_res  <= r_b_res;
            r_o_filt <= n_o_filt;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_res.calibrating;
    assign m_axis_tdata  = {3'b000, r_o_res.turns, r_o_res.angle, r_o_filt,
                            r_o_res.raw_rate, r_o_res.position};

    `MET_ASSERT_NEXT(a_calib_count, a_go && calib,
        r_items_seen == $past(r_items_seen) + 8'd1,
        "calibration item did not advance the calibration count")
    `MET_ASSERT_NEXT(a_turns_hold, a_go && !calib && !wrap_up && !wrap_dn,
        r_turns == $past(r_turns),
        "turn count changed without a wraparound")
    `MET_ASSERT_SAME(a_calib_pos, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[44:13] == 32'd0,
        "calibration result carries turns in its position")
    `MET_ASSERT_NEXT(a_mid_hold, r_b_vld && r_o_vld && !m_axis_tready,
        r_b_vld,
        "divide stage dropped an item while the output was stalled")

endmodule
